// ===== rtl/core/lrs_pkg.sv =====
// Package: shared constants, types and codes of the LRU recency stack.
package lrs_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned PageW  = 16;
  localparam int unsigned OccW   = 5;
  localparam int unsigned FillW  = $clog2(Depth + 1);

  localparam logic ReqTouch = 1'b0;
  localparam logic ReqTake  = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Request-wide command seen by every cell.
  typedef struct packed {
    logic go_take;
    logic go_touch;
    logic hit;
  } cmd_t;

  // Where a cell stands relative to the fill count.
  typedef struct packed {
    logic valid;
    logic is_top;
    logic is_free;
  } pos_t;

endpackage

// ===== rtl/core/lrs_if.sv =====
// Interfaces: request and response channels of the LRU recency stack.
interface lrs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [lrs_pkg::PageW-1:0] page;

  modport source (output valid, output req_type, output page, input ready);
  modport sink   (input valid, input req_type, input page, output ready);
endinterface

interface lrs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lrs_pkg::PageW-1:0] bottom_page;
  logic                      hit;
  logic [lrs_pkg::OccW-1:0]  occupancy;
  logic [1:0]                status;

  modport source (output valid, output bottom_page, output hit, output occupancy,
                  output status, input ready);
  modport sink   (input valid, input bottom_page, input hit, input occupancy,
                  input status, output ready);
endinterface

// ===== rtl/core/lrs_cell.sv =====
// Stack cell: holds one page slot, compares it and shifts from the cell above.
module lrs_cell (
  input  logic                      clk_i,
  input  lrs_pkg::cmd_t             cmd_i,
  input  lrs_pkg::pos_t             pos_i,
  input  logic [lrs_pkg::PageW-1:0] page_i,
  input  logic [lrs_pkg::PageW-1:0] upper_i,
  input  logic                      match_below_i,
  output logic                      match_below_o,
  output logic [lrs_pkg::PageW-1:0] entry_o
);

  logic [lrs_pkg::PageW-1:0] entry_q, entry_d;

  assign match_below_o = match_below_i | (pos_i.valid & (entry_q == page_i));
  assign entry_o       = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.go_take) begin
      entry_d = upper_i;
    end else if (cmd_i.go_touch) begin
      if (cmd_i.hit) begin
        if (pos_i.is_top) begin
          entry_d = page_i;
        end else if (pos_i.valid && match_below_o) begin
          entry_d = upper_i;
        end
      end else if (pos_i.is_free) begin
        entry_d = page_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/core/lru_recency_stack_unit.sv =====
// Top level: LRU recency stack built as a chain of page cells.
// One request a cycle: a word is taken whenever the response register is empty or being
// drained, and its response appears in the next cycle. Every cell compares its page
// against the request in parallel and shifts from its upper neighbor in the same cycle;
// the hit position travels up the chain, so the longest path is the match chain through
// all slots. Slot 0 is the least recently used page, the slot below the fill count the
// most recent.
module lru_recency_stack_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  lrs_req_if.sink      req_i,
  lrs_rsp_if.source    rsp_o
);

  localparam int unsigned Depth = lrs_pkg::Depth;
  localparam int unsigned FillW = lrs_pkg::FillW;
  localparam int unsigned PageW = lrs_pkg::PageW;

  logic [FillW-1:0] fill_q, fill_d;
  logic             valid_q;
  logic [PageW-1:0] bottom_q;
  logic             hit_q;
  logic [lrs_pkg::OccW-1:0] occ_q;
  lrs_pkg::status_e status_q;

  logic [PageW-1:0] entry   [Depth];
  logic [Depth:0]   match_chain;
  lrs_pkg::cmd_t    cmd;
  lrs_pkg::pos_t    pos [Depth];

  logic accept, is_take, is_touch, nonempty, full, hit;

  assign req_i.ready = ~valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;
  assign is_take     = (req_i.req_type == lrs_pkg::ReqTake);
  assign is_touch    = (req_i.req_type == lrs_pkg::ReqTouch);
  assign nonempty    = (fill_q != '0);
  assign full        = (fill_q == FillW'(Depth));

  assign match_chain[0] = 1'b0;
  assign hit            = match_chain[Depth];

  assign cmd.go_take  = accept & is_take & nonempty;
  assign cmd.go_touch = accept & is_touch;
  assign cmd.hit      = hit;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [PageW-1:0] upper;
    if (i == Depth - 1) begin : g_last
      assign upper = req_i.page;
    end else begin : g_mid
      assign upper = entry[i+1];
    end

    assign pos[i].valid   = (FillW'(i) < fill_q);
    assign pos[i].is_top  = (fill_q == FillW'(i + 1));
    assign pos[i].is_free = (fill_q == FillW'(i));

    lrs_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .pos_i         (pos[i]),
      .page_i        (req_i.page),
      .upper_i       (upper),
      .match_below_i (match_chain[i]),
      .match_below_o (match_chain[i+1]),
      .entry_o       (entry[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd.go_take) begin
      fill_d = fill_q - FillW'(1);
    end else if (cmd.go_touch && !hit && !full) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q  <= fill_d;
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bottom_q <= cmd.go_take ? entry[0] : '0;
      hit_q    <= is_touch & hit;
      occ_q    <= lrs_pkg::OccW'(fill_d);
      if (is_take && !nonempty) begin
        status_q <= lrs_pkg::StEmpty;
      end else if (is_touch && !hit && full) begin
        status_q <= lrs_pkg::StFull;
      end else begin
        status_q <= lrs_pkg::StOk;
      end
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.bottom_page = bottom_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.occupancy   = occ_q;
  assign rsp_o.status      = status_q;

endmodule
